>>> hw/rtl/mpo_pkg.sv
// Shared types, register indexes and the sine table builder for the phase oscillator.
`default_nettype none

package mpo_pkg;

  // Waveform select codes.
  typedef enum logic [1:0] {
    WAVE_TRIANGLE = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SINE     = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd1;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Widest table entry the builder returns (largest output width).
  localparam int unsigned SINE_ENTRY_MAX_BITS = 24;

  // Half pi in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One quarter-wave table entry: sin(k / 2^tb * pi/2) scaled to 2^(ob-1), clamped
  // to full scale. The sine is a Taylor series to the x^13 term in Q30 with
  // truncating products and divisions. Evaluated at elaboration only.
  function automatic logic [SINE_ENTRY_MAX_BITS-1:0] sine_entry(
    input int unsigned k,
    input int unsigned tb,
    input int unsigned ob
  );
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] fs;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    fs   = 64'd1 << (ob - 1);
    v    = (sum * fs + (64'd1 << 29)) >> 30;
    if (v > fs) begin
      v = fs;
    end
    return v[SINE_ENTRY_MAX_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/multiwave_phase_oscillator.sv
// Phase-accumulator oscillator: triangle, square, quarter-wave sine and saw outputs.
// A sample word is registered and appears on the output in the cycle after its request is accepted.
// Throughput: one request word per cycle; the phase add and table read share one stage.
// The input stalls only while a finished sample waits and the output is stalled.
// Synchronous reset clears the phase, the waveform (triangle) and the phase step.
// The sine table is constant logic, so no clearing pass follows reset.
`default_nettype none

module multiwave_phase_oscillator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 8,
  parameter int unsigned OUT_BITS        = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_reset_phase,
  input  logic                               in_block_end,
  // Sample channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [OUT_BITS-1:0]         out_sample,
  output logic                               out_block_last,
  // Configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpo_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mpo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mpo_pkg::*;

  localparam int unsigned TBL_N  = 1 << SINE_TABLE_BITS;
  localparam int unsigned Q_BITS = OUT_BITS + 1;
  localparam int unsigned V_BITS = OUT_BITS + 2;
  localparam int unsigned FS     = 1 << (OUT_BITS - 1);
  localparam int unsigned IDX_BITS = SINE_TABLE_BITS + 2;

  localparam logic signed [V_BITS-1:0] FS_V     = V_BITS'(FS);
  localparam logic signed [V_BITS-1:0] FS3_V    = V_BITS'(3 * FS);
  localparam logic signed [V_BITS-1:0] POS_MAX  = V_BITS'(FS - 1);
  localparam logic signed [V_BITS-1:0] NEG_MIN  = -FS_V;

  // Quarter-wave sine table, built at elaboration.
  logic [OUT_BITS-1:0] sine_rom [TBL_N+1];

  for (genvar gi = 0; gi <= TBL_N; gi++) begin : g_rom
    localparam logic [OUT_BITS-1:0] ENTRY =
      OUT_BITS'(sine_entry(gi, SINE_TABLE_BITS, OUT_BITS));
    assign sine_rom[gi] = ENTRY;
  end

  // Configuration registers; writes are always taken.
  wave_t                     waveform_r;
  logic [CFG_DATA_BITS-1:0]  phase_step_r;
  logic                      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r   <= WAVE_TRIANGLE;
      phase_step_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAVEFORM:   waveform_r   <= wave_t'(cfg_data[1:0]);
        CFG_PHASE_STEP: phase_step_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Handshake: a new word enters unless a held sample is stalled.
  logic out_valid_r;
  logic out_valid_nxt;
  logic accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Phase step aligned to the accumulator width.
  logic [PHASE_BITS+CFG_DATA_BITS-1:0] step_wide;
  logic [PHASE_BITS-1:0]               step_al;

  assign step_wide = {phase_step_r, PHASE_BITS'(0)};
  assign step_al   = step_wide[PHASE_BITS+CFG_DATA_BITS-1:CFG_DATA_BITS];

  // Phase used for this sample and the phase after it.
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] phase_nxt;

  assign phase_cur = in_reset_phase ? '0 : phase_r;
  assign phase_nxt = phase_cur + step_al;

  // Top phase bits as the waveform coordinate and the sine table index.
  logic [PHASE_BITS+Q_BITS-1:0] phase_pad;
  logic [Q_BITS-1:0]            q;
  logic [IDX_BITS-1:0]          idx;
  logic [SINE_TABLE_BITS:0]     k;
  logic [OUT_BITS-1:0]          sine_mag;

  assign phase_pad = {phase_cur, Q_BITS'(0)};
  assign q         = phase_pad[PHASE_BITS+Q_BITS-1:PHASE_BITS];
  assign idx       = phase_cur[PHASE_BITS-1:PHASE_BITS-IDX_BITS];
  assign k         = idx[SINE_TABLE_BITS] ?
                     ((SINE_TABLE_BITS+1)'(TBL_N) - {1'b0, idx[SINE_TABLE_BITS-1:0]}) :
                     {1'b0, idx[SINE_TABLE_BITS-1:0]};
  assign sine_mag  = sine_rom[k];

  // Waveform value and saturation to the signed output range.
  logic signed [V_BITS-1:0] q_s;
  logic signed [V_BITS-1:0] wave_v;
  logic signed [V_BITS-1:0] sine_v;
  logic signed [OUT_BITS-1:0] sample_nxt;

  assign q_s    = $signed({1'b0, q});
  assign sine_v = $signed({2'b00, sine_mag});

  always_comb begin
    unique case (waveform_r)
      WAVE_TRIANGLE: wave_v = q[Q_BITS-1] ? (FS3_V - q_s) : (q_s - FS_V);
      WAVE_SQUARE:   wave_v = q[Q_BITS-1] ? FS_V : '0;
      WAVE_SINE:     wave_v = idx[SINE_TABLE_BITS+1] ? -sine_v : sine_v;
      WAVE_SAW:      wave_v = $signed({3'b000, q[Q_BITS-1:2]});
      default:       wave_v = '0;
    endcase
    if (wave_v > POS_MAX) begin
      sample_nxt = POS_MAX[OUT_BITS-1:0];
    end else if (wave_v < NEG_MIN) begin
      sample_nxt = NEG_MIN[OUT_BITS-1:0];
    end else begin
      sample_nxt = wave_v[OUT_BITS-1:0];
    end
  end

  // Control state: phase accumulator and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Output word register.
  logic signed [OUT_BITS-1:0] sample_r;
  logic                       block_last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r     <= sample_nxt;
      block_last_r <= in_block_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = sample_r;
  assign out_block_last = block_last_r;

endmodule

`default_nettype wire
